@@ sv/crr_pkg.sv @@
package crr_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FORWARD_X       = 2'd0;
    localparam logic [1:0] CFG_FORWARD_Y       = 2'd1;
    localparam logic [1:0] CFG_FORWARD_Z       = 2'd2;
    localparam logic [1:0] CFG_COLLINEAR_LIMIT = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FWD_W      = 16;
    localparam int LIM_W      = 10;
    localparam int DIR_W      = 24;
    localparam int UNIT_W     = 16;

    // Unitizer: signed input width, normalized magnitude width, Q2.14 shift
    localparam int NORM_IN_W  = 42;
    localparam int MAG_W      = 31;
    localparam int UNIT_SHIFT = 14;

    // Token kinds through the unitizer
    localparam logic [1:0] KIND_ITEM  = 2'd0;
    localparam logic [1:0] KIND_UP    = 2'd1;
    localparam logic [1:0] KIND_RIGHT = 2'd2;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } crr_in_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] world_x;
        logic signed [UNIT_W-1:0] world_y;
        logic signed [UNIT_W-1:0] world_z;
        logic                     degenerate;
    } crr_out_t;

    typedef struct packed {
        logic       epoch;
        logic [1:0] kind;
    } tag_t;

    typedef struct packed {
        logic signed [NORM_IN_W-1:0] x;
        logic signed [NORM_IN_W-1:0] y;
        logic signed [NORM_IN_W-1:0] z;
    } vec_in_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] x;
        logic signed [UNIT_W-1:0] y;
        logic signed [UNIT_W-1:0] z;
    } unit_t;

endpackage

@@ sv/crr_norm.sv @@
module crr_norm import crr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    adv,
    input  logic    in_valid,
    input  tag_t    in_tag,
    input  vec_in_t in_vec,
    output logic    out_valid,
    output tag_t    out_tag,
    output unit_t   out_unit,
    output logic    out_zero
);

    localparam int POS_W     = $clog2(NORM_IN_W);
    localparam int L_W       = 2 * MAG_W + 2;
    localparam int ROOT_W    = L_W / 2;
    localparam int SQ_PER    = 2;
    localparam int SQ_STAGES = ROOT_W / SQ_PER;
    localparam int SREM_W    = ROOT_W + 4;
    localparam int Q_W       = UNIT_SHIFT + 1;
    localparam int N_W       = MAG_W + Q_W;
    localparam int DREM_W    = ROOT_W + 1;

    typedef struct packed {
        tag_t                   tag;
        logic                   zero;
        logic [2:0]             neg;
        logic [3*MAG_W-1:0]     mags;
    } carry_t;

    logic signed [NORM_IN_W-1:0] in_c [3];

    assign in_c[0] = in_vec.x;
    assign in_c[1] = in_vec.y;
    assign in_c[2] = in_vec.z;

    // Stage 0: sign and magnitude
    logic                 n0_v_reg;
    tag_t                 n0_tag_reg;
    logic [2:0]           n0_neg_reg;
    logic [NORM_IN_W-1:0] n0_mag_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n0_v_reg <= 1'b0;
        end else if (adv) begin
            n0_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n0_tag_reg <= in_tag;
            for (int c = 0; c < 3; c++) begin
                n0_neg_reg[c] <= in_c[c][NORM_IN_W-1];
                n0_mag_reg[c] <= in_c[c][NORM_IN_W-1] ? NORM_IN_W'(-in_c[c])
                                                      : NORM_IN_W'(in_c[c]);
            end
        end
    end

    // Stage 1: leading one of the largest magnitude
    logic [NORM_IN_W-1:0] orv;
    logic [POS_W-1:0]     pos_next;
    logic                 n1_v_reg;
    tag_t                 n1_tag_reg;
    logic [2:0]           n1_neg_reg;
    logic                 n1_zero_reg;
    logic [POS_W-1:0]     n1_pos_reg;
    logic [NORM_IN_W-1:0] n1_mag_reg [3];

    always_comb begin
        orv      = n0_mag_reg[0] | n0_mag_reg[1] | n0_mag_reg[2];
        pos_next = '0;
        for (int i = 0; i < NORM_IN_W; i++) begin
            if (orv[i]) begin
                pos_next = POS_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_v_reg <= 1'b0;
        end else if (adv) begin
            n1_v_reg <= n0_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n1_tag_reg  <= n0_tag_reg;
            n1_neg_reg  <= n0_neg_reg;
            n1_zero_reg <= (orv == '0);
            n1_pos_reg  <= pos_next;
            for (int c = 0; c < 3; c++) begin
                n1_mag_reg[c] <= n0_mag_reg[c];
            end
        end
    end

    // Stage 2: bring the largest magnitude into [2^30, 2^31)
    logic [3*MAG_W-1:0] mags_next;
    logic               c2_v_reg;
    carry_t             c2_reg;

    always_comb begin
        logic [NORM_IN_W-1:0] t;
        mags_next = '0;
        for (int c = 0; c < 3; c++) begin
            if (n1_pos_reg > POS_W'(MAG_W - 1)) begin
                t = n1_mag_reg[c] >> (n1_pos_reg - POS_W'(MAG_W - 1));
            end else begin
                t = n1_mag_reg[c] << (POS_W'(MAG_W - 1) - n1_pos_reg);
            end
            mags_next[c*MAG_W +: MAG_W] = t[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_v_reg <= 1'b0;
        end else if (adv) begin
            c2_v_reg <= n1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c2_reg.tag  <= n1_tag_reg;
            c2_reg.zero <= n1_zero_reg;
            c2_reg.neg  <= n1_neg_reg;
            c2_reg.mags <= mags_next;
        end
    end

    // Stage 3: squares, stage 4: sum of squares
    logic               c3_v_reg;
    carry_t             c3_reg;
    logic [2*MAG_W-1:0] n3_sq_reg [3];
    logic               c4_v_reg;
    carry_t             c4_reg;
    logic [L_W-1:0]     n4_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_v_reg <= 1'b0;
            c4_v_reg <= 1'b0;
        end else if (adv) begin
            c3_v_reg <= c2_v_reg;
            c4_v_reg <= c3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c3_reg <= c2_reg;
            for (int c = 0; c < 3; c++) begin
                n3_sq_reg[c] <= c2_reg.mags[c*MAG_W +: MAG_W]
                              * c2_reg.mags[c*MAG_W +: MAG_W];
            end
            c4_reg     <= c3_reg;
            n4_sum_reg <= L_W'(n3_sq_reg[0]) + L_W'(n3_sq_reg[1]) + L_W'(n3_sq_reg[2]);
        end
    end

    // Square root, two result bits per stage
    logic [L_W-1:0]    sq_x_reg    [SQ_STAGES];
    logic [SREM_W-1:0] sq_rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0] sq_root_reg [SQ_STAGES];
    carry_t            sq_c_reg    [SQ_STAGES];
    logic              sq_v_reg    [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
        logic [L_W-1:0]    x_in;
        logic [SREM_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        carry_t            c_in;
        logic              v_in;
        logic [L_W-1:0]    x_nx;
        logic [SREM_W-1:0] rem_nx;
        logic [ROOT_W-1:0] root_nx;

        if (k == 0) begin : g_first
            assign x_in    = n4_sum_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign c_in    = c4_reg;
            assign v_in    = c4_v_reg;
        end else begin : g_next
            assign x_in    = sq_x_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign c_in    = sq_c_reg[k-1];
            assign v_in    = sq_v_reg[k-1];
        end

        always_comb begin
            logic [SREM_W-1:0] t;
            logic [SREM_W-1:0] trial;
            x_nx    = x_in;
            rem_nx  = rem_in;
            root_nx = root_in;
            for (int i = 0; i < SQ_PER; i++) begin
                t     = SREM_W'({rem_nx, x_nx[L_W-1 -: 2]});
                trial = SREM_W'({root_nx, 2'b01});
                if (t >= trial) begin
                    rem_nx  = t - trial;
                    root_nx = ROOT_W'({root_nx, 1'b1});
                end else begin
                    rem_nx  = t;
                    root_nx = ROOT_W'({root_nx, 1'b0});
                end
                x_nx = x_nx << 2;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_x_reg[k]    <= x_nx;
                sq_rem_reg[k]  <= rem_nx;
                sq_root_reg[k] <= root_nx;
                sq_c_reg[k]    <= c_in;
            end
        end
    end

    // Division of each magnitude by the root, one quotient bit per stage
    logic [DREM_W-1:0] dv_rem_reg [Q_W][3];
    logic [Q_W-1:0]    dv_nlo_reg [Q_W][3];
    logic [Q_W-1:0]    dv_q_reg   [Q_W][3];
    logic [ROOT_W-1:0] dv_d_reg   [Q_W];
    carry_t            dv_c_reg   [Q_W];
    logic              dv_v_reg   [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_dv
        logic [DREM_W-1:0] rem_in [3];
        logic [Q_W-1:0]    nlo_in [3];
        logic [Q_W-1:0]    q_in   [3];
        logic [ROOT_W-1:0] d_in;
        carry_t            c_in;
        logic              v_in;
        logic [DREM_W-1:0] rem_nx [3];
        logic [Q_W-1:0]    nlo_nx [3];
        logic [Q_W-1:0]    q_nx   [3];

        if (j == 0) begin : g_first
            assign d_in = sq_root_reg[SQ_STAGES-1];
            assign c_in = sq_c_reg[SQ_STAGES-1];
            assign v_in = sq_v_reg[SQ_STAGES-1];
            always_comb begin
                logic [N_W-1:0] n;
                for (int c = 0; c < 3; c++) begin
                    n = (N_W'(c_in.mags[c*MAG_W +: MAG_W]) << UNIT_SHIFT)
                      + N_W'(d_in >> 1);
                    rem_in[c] = DREM_W'(n[N_W-1:Q_W]);
                    nlo_in[c] = n[Q_W-1:0];
                    q_in[c]   = '0;
                end
            end
        end else begin : g_next
            assign d_in = dv_d_reg[j-1];
            assign c_in = dv_c_reg[j-1];
            assign v_in = dv_v_reg[j-1];
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    rem_in[c] = dv_rem_reg[j-1][c];
                    nlo_in[c] = dv_nlo_reg[j-1][c];
                    q_in[c]   = dv_q_reg[j-1][c];
                end
            end
        end

        always_comb begin
            logic [DREM_W-1:0] t;
            for (int c = 0; c < 3; c++) begin
                t = DREM_W'({rem_in[c], nlo_in[c][Q_W-1]});
                if (t >= DREM_W'(d_in)) begin
                    rem_nx[c] = t - DREM_W'(d_in);
                    q_nx[c]   = Q_W'({q_in[c], 1'b1});
                end else begin
                    rem_nx[c] = t;
                    q_nx[c]   = Q_W'({q_in[c], 1'b0});
                end
                nlo_nx[c] = nlo_in[c] << 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_d_reg[j] <= d_in;
                dv_c_reg[j] <= c_in;
                for (int c = 0; c < 3; c++) begin
                    dv_rem_reg[j][c] <= rem_nx[c];
                    dv_nlo_reg[j][c] <= nlo_nx[c];
                    dv_q_reg[j][c]   <= q_nx[c];
                end
            end
        end
    end

    // Output stage: restore signs, force zero for the null vector
    logic        out_v_reg;
    tag_t        out_tag_reg;
    logic        out_zero_reg;
    unit_t       out_unit_reg;
    logic signed [UNIT_W-1:0] comp_next [3];
    carry_t      last_c;

    assign last_c = dv_c_reg[Q_W-1];

    always_comb begin
        logic [UNIT_W-1:0] q;
        for (int c = 0; c < 3; c++) begin
            q = UNIT_W'(dv_q_reg[Q_W-1][c]);
            if (last_c.zero) begin
                comp_next[c] = '0;
            end else if (last_c.neg[c]) begin
                comp_next[c] = -$signed(q);
            end else begin
                comp_next[c] = $signed(q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= dv_v_reg[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_tag_reg    <= last_c.tag;
            out_zero_reg   <= last_c.zero;
            out_unit_reg.x <= comp_next[0];
            out_unit_reg.y <= comp_next[1];
            out_unit_reg.z <= comp_next[2];
        end
    end

    assign out_valid = out_v_reg;
    assign out_tag   = out_tag_reg;
    assign out_unit  = out_unit_reg;
    assign out_zero  = out_zero_reg;

endmodule

@@ sv/camera_look_at_ray_rotate_unit.sv @@
// Look-at camera ray rotation.
// Input channel (s_valid/s_ready/s_data): one camera-space ray direction per
// transaction, three Q12.12 components. Result channel (m_valid/m_ready/
// m_data): the unit world direction in Q2.14 plus a degenerate flag, which is
// set (with zero components) when the rotated vector has zero length.
// Configuration: cfg_we/cfg_index/cfg_data write forward x, y, z and the
// collinear limit; write them only while no transaction is in flight.
// Throughput: one transaction per cycle while no basis rebuild is running and
// the output buffer has room. Each ray passes through the 16-stage square root
// and the 15-stage quotient pipeline of the shared unitizer.
// After reset and after every configuration write the up and right basis
// vectors are rebuilt by sending them through the same unitizer; s_ready
// stays low until the rebuilt right vector has come back.
// The result side ends in a two-entry output buffer, so a result waiting on
// m_ready does not stop the pipeline; only when both entries are full does
// the whole pipeline hold and s_ready drop. Nothing is lost or repeated.
module camera_look_at_ray_rotate_unit import crr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  crr_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crr_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_READY  = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_INJ_UP = 3'd2;
    localparam logic [2:0] ST_INJ_RT = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;

    localparam int PROD_W = UNIT_W + DIR_W;
    localparam int FP_W   = 2 * FWD_W;

    // Configuration registers
    logic signed [FWD_W-1:0] fx_reg, fy_reg, fz_reg;
    logic [LIM_W-1:0]        lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fx_reg  <= '0;
            fy_reg  <= '0;
            fz_reg  <= FWD_W'(1 << UNIT_SHIFT);
            lim_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FORWARD_X:       fx_reg  <= cfg_data[FWD_W-1:0];
                CFG_FORWARD_Y:       fy_reg  <= cfg_data[FWD_W-1:0];
                CFG_FORWARD_Z:       fz_reg  <= cfg_data[FWD_W-1:0];
                CFG_COLLINEAR_LIMIT: lim_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Unnormalized up and right from forward; hold in registers for injection
    logic signed [FWD_W:0]  fxe, fze, lim_s;
    logic                   vertical;
    logic signed [FP_W-1:0] pxy, pxx, pzz, pyz, pyy, pxz;
    vec_in_t                up_src_next, rt_src_next;
    vec_in_t                up_src_reg, rt_src_reg;

    always_comb begin
        fxe      = (FWD_W+1)'(fx_reg);
        fze      = (FWD_W+1)'(fz_reg);
        lim_s    = $signed({{(FWD_W+1-LIM_W){1'b0}}, lim_reg});
        vertical = (fxe <= lim_s) && (-fxe <= lim_s) && (fze <= lim_s) && (-fze <= lim_s);
        pxy = fx_reg * fy_reg;
        pxx = fx_reg * fx_reg;
        pzz = fz_reg * fz_reg;
        pyz = fy_reg * fz_reg;
        pyy = fy_reg * fy_reg;
        pxz = fx_reg * fz_reg;
        if (!vertical) begin
            rt_src_next.x = NORM_IN_W'(fz_reg);
            rt_src_next.y = '0;
            rt_src_next.z = -NORM_IN_W'(fx_reg);
            up_src_next.x = -NORM_IN_W'(pxy);
            up_src_next.y = NORM_IN_W'(pxx) + NORM_IN_W'(pzz);
            up_src_next.z = -NORM_IN_W'(pyz);
        end else begin
            up_src_next.x = '0;
            up_src_next.y = NORM_IN_W'(fz_reg);
            up_src_next.z = -NORM_IN_W'(fy_reg);
            rt_src_next.x = NORM_IN_W'(pzz) + NORM_IN_W'(pyy);
            rt_src_next.y = -NORM_IN_W'(pxy);
            rt_src_next.z = -NORM_IN_W'(pxz);
        end
    end

    always_ff @(posedge aclk) begin
        up_src_reg <= up_src_next;
        rt_src_reg <= rt_src_next;
    end

    // Pipeline advance: hold everything only when the output buffer is full
    logic [1:0] cnt_reg;
    logic       adv;
    logic [2:0] state_reg;
    logic       epoch_reg;

    assign adv     = (cnt_reg != 2'd2);
    assign s_ready = adv && (state_reg == ST_READY);

    // Basis vectors, rebuilt by the unitizer
    logic signed [UNIT_W-1:0] rb_reg [3];
    logic signed [UNIT_W-1:0] ub_reg [3];

    // Stage M: the nine products of the rotation
    logic                     m_v_reg;
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [DIR_W-1:0]  dir_c [3];
    logic signed [FWD_W-1:0]  fwd_c [3];

    assign dir_c[0] = s_data.dir_x;
    assign dir_c[1] = s_data.dir_y;
    assign dir_c[2] = s_data.dir_z;
    assign fwd_c[0] = fx_reg;
    assign fwd_c[1] = fy_reg;
    assign fwd_c[2] = fz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
        end else if (adv) begin
            m_v_reg <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                prod_reg[c][0] <= rb_reg[c] * dir_c[0];
                prod_reg[c][1] <= ub_reg[c] * dir_c[1];
                prod_reg[c][2] <= fwd_c[c] * dir_c[2];
            end
        end
    end

    // Stage S: sum each row
    logic                        sm_v_reg;
    logic signed [NORM_IN_W-1:0] sum_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sm_v_reg <= 1'b0;
        end else if (adv) begin
            sm_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= NORM_IN_W'(prod_reg[c][0]) + NORM_IN_W'(prod_reg[c][1])
                            + NORM_IN_W'(prod_reg[c][2]);
            end
        end
    end

    // Unitizer input: items, or basis vectors while rebuilding
    logic    nin_valid;
    tag_t    nin_tag;
    vec_in_t nin_vec;
    logic    nout_valid;
    tag_t    nout_tag;
    unit_t   nout_unit;
    logic    nout_zero;

    always_comb begin
        nin_tag.epoch = epoch_reg;
        nin_valid     = sm_v_reg;
        nin_tag.kind  = KIND_ITEM;
        nin_vec.x     = sum_reg[0];
        nin_vec.y     = sum_reg[1];
        nin_vec.z     = sum_reg[2];
        if (state_reg == ST_INJ_UP) begin
            nin_valid    = 1'b1;
            nin_tag.kind = KIND_UP;
            nin_vec      = up_src_reg;
        end else if (state_reg == ST_INJ_RT) begin
            nin_valid    = 1'b1;
            nin_tag.kind = KIND_RIGHT;
            nin_vec      = rt_src_reg;
        end
    end

    crr_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (nin_valid),
        .in_tag    (nin_tag),
        .in_vec    (nin_vec),
        .out_valid (nout_valid),
        .out_tag   (nout_tag),
        .out_unit  (nout_unit),
        .out_zero  (nout_zero)
    );

    // Basis rebuild sequencer; restart on every configuration write
    logic right_done;

    assign right_done = adv && nout_valid && (nout_tag.kind == KIND_RIGHT)
                     && (nout_tag.epoch == epoch_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_PREP;
            epoch_reg <= 1'b0;
        end else if (cfg_we) begin
            state_reg <= ST_PREP;
            epoch_reg <= !epoch_reg;
        end else begin
            unique case (state_reg)
                ST_READY:  state_reg <= ST_READY;
                ST_PREP:   state_reg <= ST_INJ_UP;
                ST_INJ_UP: if (adv) begin
                    state_reg <= ST_INJ_RT;
                end
                ST_INJ_RT: if (adv) begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:   if (right_done) begin
                    state_reg <= ST_READY;
                end
                default:   state_reg <= ST_PREP;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && nout_valid && (nout_tag.kind == KIND_UP)) begin
            ub_reg[0] <= nout_unit.x;
            ub_reg[1] <= nout_unit.y;
            ub_reg[2] <= nout_unit.z;
        end
        if (adv && nout_valid && (nout_tag.kind == KIND_RIGHT)) begin
            rb_reg[0] <= nout_unit.x;
            rb_reg[1] <= nout_unit.y;
            rb_reg[2] <= nout_unit.z;
        end
    end

    // Two-entry output buffer
    crr_out_t buf0_reg, buf1_reg;
    crr_out_t res_next;
    logic     push, pop;

    assign push = adv && nout_valid && (nout_tag.kind == KIND_ITEM);
    assign pop  = m_valid && m_ready;

    always_comb begin
        res_next.world_x    = nout_unit.x;
        res_next.world_y    = nout_unit.y;
        res_next.world_z    = nout_unit.z;
        res_next.degenerate = nout_zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)) begin
            if (push) begin
                buf0_reg <= res_next;
            end
        end else if (cnt_reg == 2'd1) begin
            if (push) begin
                buf1_reg <= res_next;
            end
        end else if (pop) begin
            buf0_reg <= buf1_reg;
        end
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = buf0_reg;

`ifndef SYNTHESIS
    // A full buffer that is not drained must stay full: the pipeline holds
    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) && !m_ready |=> (cnt_reg == 2'd2))
        else $error("output buffer changed while full and stalled");

    // Items are taken only once the basis rebuild has completed
    a_ready_after_right: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_READY) |-> $past(right_done))
        else $error("basis marked ready without a right vector");

    // A degenerate result carries zero components
    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            (m_data.world_x == '0) && (m_data.world_y == '0) && (m_data.world_z == '0))
        else $error("degenerate result with non-zero components");
`endif

endmodule

@@ test/crr_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels and the configuration port of the ray rotate unit.
// Predicts the unit world direction of every accepted ray and compares it
// with the results in order.
module crr_checker import crr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  crr_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  crr_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    logic signed [FWD_W-1:0] fwd_x, fwd_y, fwd_z;
    logic        [LIM_W-1:0] vert_limit;
    crr_out_t                world_dir_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Scale a vector to unit length in Q2.14; return 0 for the zero vector.
    function automatic bit to_unit(input longint v0, input longint v1, input longint v2,
                                   output int o0, output int o1, output int o2);
        longint          v[3];
        longint unsigned mag[3], big, len2, root, q;
        bit              neg[3];
        int              o[3];
        v[0] = v0; v[1] = v1; v[2] = v2;
        big = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > big) big = mag[i];
        end
        if (big == 0) begin
            o0 = 0; o1 = 0; o2 = 0;
            return 0;
        end
        while (big >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            big = big >> 1;
        end
        while (big < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            big = big << 1;
        end
        len2 = 0;
        for (int i = 0; i < 3; i++) len2 = len2 + mag[i] * mag[i];
        root = int_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + root / 2) / root;
            if (q > 32767) q = 32767;
            o[i] = neg[i] ? -int'(q) : int'(q);
        end
        o0 = o[0]; o1 = o[1]; o2 = o[2];
        return 1;
    endfunction

    function automatic crr_out_t rotate_ray(input crr_in_t d);
        longint   fx, fy, fz, lim, dx, dy, dz;
        longint   rv[3], uv[3];
        int       rx, ry, rz, ux, uy, uz, ox, oy, oz;
        bit       vertical, nonzero;
        crr_out_t res;
        fx  = fwd_x;  fy = fwd_y;  fz = fwd_z;
        lim = longint'(vert_limit);
        dx  = d.dir_x; dy = d.dir_y; dz = d.dir_z;
        vertical = (fx <= lim) && (-fx <= lim) && (fz <= lim) && (-fz <= lim);
        if (!vertical) begin
            rv[0] = fz;       rv[1] = 0;                 rv[2] = -fx;
            uv[0] = -fx * fy; uv[1] = fx * fx + fz * fz; uv[2] = -fy * fz;
        end else begin
            uv[0] = 0;                 uv[1] = fz;       uv[2] = -fy;
            rv[0] = fz * fz + fy * fy; rv[1] = -fx * fy; rv[2] = -fx * fz;
        end
        void'(to_unit(uv[0], uv[1], uv[2], ux, uy, uz));
        void'(to_unit(rv[0], rv[1], rv[2], rx, ry, rz));
        nonzero = to_unit(longint'(rx) * dx + longint'(ux) * dy + fx * dz,
                          longint'(ry) * dx + longint'(uy) * dy + fy * dz,
                          longint'(rz) * dx + longint'(uz) * dy + fz * dz,
                          ox, oy, oz);
        res.world_x    = ox[UNIT_W-1:0];
        res.world_y    = oy[UNIT_W-1:0];
        res.world_z    = oz[UNIT_W-1:0];
        res.degenerate = !nonzero;
        return res;
    endfunction

    assign outstanding = world_dir_q.size();

    initial mismatches = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            fwd_x      <= '0;
            fwd_y      <= '0;
            fwd_z      <= 16'sd16384;
            vert_limit <= '0;
            world_dir_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FORWARD_X:       fwd_x      <= cfg_data;
                    CFG_FORWARD_Y:       fwd_y      <= cfg_data;
                    CFG_FORWARD_Z:       fwd_z      <= cfg_data;
                    CFG_COLLINEAR_LIMIT: vert_limit <= cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                world_dir_q.push_back(rotate_ray(s_data));
            if (m_valid && m_ready) begin
                if (world_dir_q.size() == 0) begin
                    $error("result with nothing expected: %p", m_data);
                    mismatches++;
                end else begin
                    crr_out_t exp_dir;
                    exp_dir = world_dir_q.pop_front();
                    if (m_data.world_x !== exp_dir.world_x) begin
                        $error("world_x expected %0d got %0d", exp_dir.world_x, m_data.world_x);
                        mismatches++;
                    end
                    if (m_data.world_y !== exp_dir.world_y) begin
                        $error("world_y expected %0d got %0d", exp_dir.world_y, m_data.world_y);
                        mismatches++;
                    end
                    if (m_data.world_z !== exp_dir.world_z) begin
                        $error("world_z expected %0d got %0d", exp_dir.world_z, m_data.world_z);
                        mismatches++;
                    end
                    if (m_data.degenerate !== exp_dir.degenerate) begin
                        $error("degenerate expected %0b got %0b",
                               exp_dir.degenerate, m_data.degenerate);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

@@ test/tb_camera_look_at_ray_rotate_unit.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the look-at ray rotate unit; checking is done by
// crr_checker, which sits beside the block.
module tb_camera_look_at_ray_rotate_unit;
    import crr_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES     = 8;
    localparam int RAYS_PER_PHASE = 39;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    crr_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    crr_out_t              m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles;
    int                    burst_left;
    int                    stall_mode;

    camera_look_at_ray_rotate_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    crr_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: switch between always ready, random stalls and long stalls.
    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one ray; open a new burst after a random gap when the last one ends.
    task automatic send_ray(input crr_in_t ray);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_data  <= ray;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    // Hold off until every result has come, then let the pipe settle.
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_forward(input logic [15:0] fx, input logic [15:0] fy,
                                 input logic [15:0] fz, input logic [15:0] lim);
        cfg_we <= 1'b1; cfg_index <= CFG_FORWARD_X;       cfg_data <= fx;
        @(posedge aclk);
        cfg_index <= CFG_FORWARD_Y;       cfg_data <= fy;
        @(posedge aclk);
        cfg_index <= CFG_FORWARD_Z;       cfg_data <= fz;
        @(posedge aclk);
        cfg_index <= CFG_COLLINEAR_LIMIT; cfg_data <= lim;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [DIR_W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1:       return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
            2:       return 24'sd0;
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic send_directed();
        send_ray('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
        send_ray('{24'sh800000, 24'sh800000, 24'sh800000});
        send_ray('{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF});
        // zero direction rotates to zero: degenerate flag
        send_ray('{24'sd0, 24'sd0, 24'sd0});
        send_ray('{24'sd4096, 24'sd0, 24'sd0});
        send_ray('{24'sd0, 24'sd4096, 24'sd0});
        send_ray('{24'sd0, 24'sd0, 24'sd4096});
        send_ray('{-24'sd1, 24'sd0, 24'sd0});
        send_ray('{24'sd0, 24'sd0, 24'sd1});
        send_ray('{24'sd1, -24'sd1, 24'sd1});
        send_ray('{24'sh555555, 24'shAAAAAA, 24'sh0F0F0F});
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        stall_mode = 0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_FORWARD_X;
        cfg_data   = '0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: ;  // reset forward, looking down +z
                // vertical forward: up is taken from the world x axis
                1: write_forward(16'd0, 16'd16384, 16'd0, 16'd0);
                2: write_forward(16'h8000, 16'h8000, 16'h8000, 16'd1023);
                3: write_forward(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0);
                // nearly vertical, within the tolerance
                4: write_forward(16'd100, 16'hC180, 16'hFFCE, 16'd100);
                // zero forward: basis collapses, every ray degenerate
                5: write_forward(16'd0, 16'd0, 16'd0, 16'd1023);
                default: write_forward(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                       16'($urandom_range(0, 1023)));
            endcase
            send_directed();
            for (int n = 0; n < RAYS_PER_PHASE; n++)
                send_ray('{rand_comp(), rand_comp(), rand_comp()});
            drain();
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/crr_pkg.sv
sv/crr_norm.sv
sv/camera_look_at_ray_rotate_unit.sv
test/crr_checker.sv
test/tb_camera_look_at_ray_rotate_unit.sv
